>>> rtl/assert_macros.svh
// Assertion macros for the RTL files; only the top level includes them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define AST_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Next-cycle implication
`define AST_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

>>> rtl/csra_pkg.sv
// Types, constants and codes of the current-sense rolling average
package csra_pkg;

   localparam int RAW_W    = 10;
   localparam int SUPPLY_W = 16;
   localparam int GAIN_W   = 16;
   localparam int DATA_W   = 16;
   localparam int SHIFT_W  = 4;
   localparam int Q_SHIFT  = 10;
   localparam int PROD_W   = RAW_W + 1 + GAIN_W;
   localparam int MVP_W    = RAW_W + SUPPLY_W;
   localparam int MV_W     = 19;
   localparam int DVD_W    = 28;

   localparam int AVG_DEPTH_DEF      = 8;
   localparam int ADC_FULL_SCALE_DEF = 1023;

   localparam logic [9:0] MV_SCALE = 10'd1000;

   localparam logic [RAW_W-1:0]   OFFSET_RST = '0;
   localparam logic [GAIN_W-1:0]  GAIN_RST   = 16'd1024;
   localparam logic [DATA_W-1:0]  SHUNT_RST  = 16'd1;
   localparam logic [SHIFT_W-1:0] SHIFT_RST  = 4'd4;

   typedef enum logic [1:0] {
      CSR_OFFSET,
      CSR_GAIN,
      CSR_SHUNT,
      CSR_SHIFT
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_SCALE,
      ST_DIV1_GO,
      ST_DIV1_WAIT,
      ST_DIV2_GO,
      ST_DIV2_WAIT,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic [RAW_W-1:0]    raw_sample;
      logic [SUPPLY_W-1:0] supply_mv;
   } req_item_type;

   typedef struct packed {
      logic [DATA_W-1:0] current_ma;
      logic [DATA_W-1:0] average_ma;
   } rsp_item_type;

   typedef struct packed {
      csr_index_type     reg_index;
      logic [DATA_W-1:0] data;
   } csr_item_type;

   typedef struct packed {
      logic              start;
      logic [DVD_W-1:0]  dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic              lookup;
      logic              commit;
      logic [DATA_W-1:0] sample;
   } ring_ctl_type;

endpackage

>>> rtl/csra_chan_if.sv
// Valid/ready channel carrying one item of a given payload type
interface csra_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

>>> rtl/csra_div.sv
// Bit-serial restoring divider, one quotient bit per cycle
module csra_div
   import csra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] rem_ff;
   logic [DVD_W-1:0]  dvd_ff;
   logic [DATA_W-1:0] dsr_ff;

   logic [DATA_W:0]   partial;
   logic [DATA_W:0]   trial;
   logic              fits;

   assign partial = {rem_ff, dvd_ff[DVD_W-1]};
   assign trial   = partial - {1'b0, dsr_ff};
   assign fits    = (partial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= '0;
         dvd_ff <= div_req.dividend;
         dsr_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? trial[DATA_W-1:0] : partial[DATA_W-1:0];
         dvd_ff <= {dvd_ff[DVD_W-2:0], fits};
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dvd_ff;

endmodule

>>> rtl/csra_ring.sv
// Sample ring with valid bits and running sum for the rolling average
module csra_ring
   import csra_pkg::*;
#(
   parameter int AVG_DEPTH = AVG_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  ring_ctl_type      ring_ctl,
   output logic [DATA_W-1:0] average_ma
);

   localparam int IDX_W = $clog2(AVG_DEPTH);
   localparam int SUM_W = DATA_W + IDX_W;
   localparam int AVG_SHIFT = $clog2(AVG_DEPTH + 1) - 1;

   logic [DATA_W-1:0]    ring_mem [AVG_DEPTH];
   logic [AVG_DEPTH-1:0] valid_ff;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [DATA_W-1:0]    old_ff;
   logic [SUM_W-1:0]     avg_full;

   assign idx_in = (idx_ff == IDX_W'(AVG_DEPTH - 1)) ? '0 : idx_ff + IDX_W'(1);
   assign sum_in = sum_ff - SUM_W'(old_ff) + SUM_W'(ring_ctl.sample);
   assign avg_full = sum_in >> AVG_SHIFT;
   assign average_ma = avg_full[DATA_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         idx_ff   <= '0;
         sum_ff   <= '0;
      end else if (ring_ctl.commit) begin
         valid_ff[idx_ff] <= 1'b1;
         idx_ff           <= idx_in;
         sum_ff           <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_ctl.commit) begin
         ring_mem[idx_ff] <= ring_ctl.sample;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_ctl.lookup) begin
         old_ff <= valid_ff[idx_ff] ? ring_mem[idx_ff] : '0;
      end
   end

endmodule

>>> rtl/current_sense_rolling_average.sv
// Top level of the current-sense rolling average
//
//   channel   direction  payload
//   req_chan  in         raw_sample[9:0], supply_mv[15:0]
//   rsp_chan  out        current_ma[15:0], average_ma[15:0]
//   csr_chan  in         reg_index[1:0], data[15:0]
//
// Each item makes two 28-step passes through the shared bit-serial divider; no new item
// is taken until the last one has been committed to the output register.
// The next item is taken while a result still waits in the output register.
// Synchronous reset clears the control state and the ring valid bits, index and sum, and
// loads the configuration registers with their reset values. csr_chan is always ready.
`include "assert_macros.svh"

module current_sense_rolling_average
   import csra_pkg::*;
#(
   parameter int AVG_DEPTH      = AVG_DEPTH_DEF,
   parameter int ADC_FULL_SCALE = ADC_FULL_SCALE_DEF
) (
   input logic          clock,
   input logic          reset,
   csra_chan_if.sink    req_chan,
   csra_chan_if.source  rsp_chan,
   csra_chan_if.sink    csr_chan
);

   state_type state_ff, state_in;

   logic [RAW_W-1:0]   offset_ff;
   logic [GAIN_W-1:0]  gain_ff;
   logic [DATA_W-1:0]  shunt_ff;
   logic [SHIFT_W-1:0] shift_ff;

   logic [RAW_W-1:0]    raw_ff;
   logic [SUPPLY_W-1:0] supply_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [MVP_W-1:0]    mvprod_ff, mvprod_in;
   logic [DVD_W-1:0]    kprod_ff, kprod_in;
   logic [DATA_W-1:0]   ma_ff, ma_in;

   rsp_item_type rsp_ff;
   logic         rsp_valid_ff, rsp_valid_in;

   logic signed [RAW_W:0]       diff;
   logic [PROD_W-Q_SHIFT-1:0]   prod_q;
   logic                        prod_pos;
   logic [RAW_W-1:0]            code;
   logic [MV_W-1:0]             mv;
   logic [DVD_W-1:0]            shifted;
   logic [DATA_W-1:0]           shunt_eff;
   logic [DATA_W-1:0]           ring_avg;

   logic req_accept;
   logic req_ready;
   logic commit_go;

   div_req_type  div_req;
   div_rsp_type  div_rsp;
   ring_ctl_type ring_ctl;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RST;
         gain_ff   <= GAIN_RST;
         shunt_ff  <= SHUNT_RST;
         shift_ff  <= SHIFT_RST;
      end else if (csr_chan.valid) begin
         case (csr_chan.payload.reg_index)
            CSR_OFFSET: offset_ff <= csr_chan.payload.data[RAW_W-1:0];
            CSR_GAIN:   gain_ff   <= csr_chan.payload.data;
            CSR_SHUNT:  shunt_ff  <= csr_chan.payload.data;
            CSR_SHIFT:  shift_ff  <= csr_chan.payload.data[SHIFT_W-1:0];
            default:    offset_ff <= offset_ff;
         endcase
      end
   end

   assign csr_chan.ready = 1'b1;

   // datapath
   assign diff     = $signed({1'b0, raw_ff}) - $signed({1'b0, offset_ff});
   assign prod_in  = PROD_W'(diff) * PROD_W'($signed(gain_ff));
   assign prod_q   = prod_ff[PROD_W-1:Q_SHIFT];
   assign prod_pos = !prod_ff[PROD_W-1] && (prod_ff != '0);
   assign code     = !prod_pos ? '0 :
                     (|prod_q[PROD_W-Q_SHIFT-1:RAW_W]) ? '1 : prod_q[RAW_W-1:0];
   assign mvprod_in = MVP_W'(code) * MVP_W'(supply_ff);
   assign mv        = div_rsp.quotient[MV_W-1:0];
   assign kprod_in  = DVD_W'(mv) * DVD_W'(MV_SCALE);
   assign shifted   = div_rsp.quotient >> shift_ff;
   assign ma_in     = (|shifted[DVD_W-1:DATA_W]) ? '1 : shifted[DATA_W-1:0];
   assign shunt_eff = (shunt_ff == '0) ? DATA_W'(1) : shunt_ff;

   assign req_accept = req_chan.valid && req_ready;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         raw_ff    <= req_chan.payload.raw_sample;
         supply_ff <= req_chan.payload.supply_mv;
      end
      if (state_ff == ST_MULT) begin
         prod_ff <= prod_in;
      end
      if (state_ff == ST_SCALE) begin
         mvprod_ff <= mvprod_in;
      end
      if (state_ff == ST_DIV1_WAIT && div_rsp.done) begin
         kprod_ff <= kprod_in;
      end
      if (state_ff == ST_DIV2_WAIT && div_rsp.done) begin
         ma_ff <= ma_in;
      end
      if (commit_go) begin
         rsp_ff.current_ma <= ma_ff;
         rsp_ff.average_ma <= ring_avg;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_accept) state_in = ST_MULT;
         ST_MULT:      state_in = ST_SCALE;
         ST_SCALE:     state_in = ST_DIV1_GO;
         ST_DIV1_GO:   state_in = ST_DIV1_WAIT;
         ST_DIV1_WAIT: if (div_rsp.done) state_in = ST_DIV2_GO;
         ST_DIV2_GO:   state_in = ST_DIV2_WAIT;
         ST_DIV2_WAIT: if (div_rsp.done) state_in = ST_COMMIT;
         ST_COMMIT:    if (!rsp_valid_ff || rsp_chan.ready) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready        = 1'b0;
      commit_go        = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = kprod_ff;
      div_req.divisor  = shunt_eff;
      ring_ctl.lookup  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            ring_ctl.lookup = req_chan.valid;
         end
         ST_DIV1_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = DVD_W'(mvprod_ff);
            div_req.divisor  = DATA_W'(ADC_FULL_SCALE);
         end
         ST_DIV2_GO: div_req.start = 1'b1;
         ST_COMMIT:  commit_go = !rsp_valid_ff || rsp_chan.ready;
         default:    req_ready = 1'b0;
      endcase
      ring_ctl.commit = commit_go;
      ring_ctl.sample = ma_ff;
   end

   assign rsp_valid_in = commit_go ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   csra_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   csra_ring #(
      .AVG_DEPTH (AVG_DEPTH)
   ) u_ring (
      .clock      (clock),
      .reset      (reset),
      .ring_ctl   (ring_ctl),
      .average_ma (ring_avg)
   );

   `AST_IMPL(a_div_done_in_wait, clock, reset, div_rsp.done,
      (state_ff == ST_DIV1_WAIT || state_ff == ST_DIV2_WAIT))
   `AST_NEXT(a_commit_loads_rsp, clock, reset, commit_go, rsp_valid_ff)
   `AST_NEXT(a_hold_commit_when_full, clock, reset,
      (state_ff == ST_COMMIT && rsp_valid_ff && !rsp_chan.ready), (state_ff == ST_COMMIT))

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// Testbench of the current-sense rolling average: table of directed samples, then paced random samples
module tb;
   import csra_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int SEGMENTS     = 12;
   localparam int SEG_ITEMS    = 50;
   localparam int DRAIN_CYCLES = 70;
   localparam int DEPTH_SHIFT  = $clog2(AVG_DEPTH_DEF);
   localparam int CODE_MAX     = (1 << RAW_W) - 1;
   localparam int DIR_ROWS     = 20;

   typedef struct packed {
      logic [RAW_W-1:0]    cfg_offset;
      logic [GAIN_W-1:0]   cfg_gain;
      logic [DATA_W-1:0]   cfg_shunt;
      logic [SHIFT_W-1:0]  cfg_shift;
      logic [RAW_W-1:0]    raw;
      logic [SUPPLY_W-1:0] supply;
      logic                chk_cur;
      logic                chk_avg;
      logic [DATA_W-1:0]   cur;
      logic [DATA_W-1:0]   avg;
   } dir_row_type;

   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      '{10'd0,     16'd1024,  16'd1,     4'd4,  10'd0,     16'd0,     1'b1, 1'b1, 16'd0,     16'd0},
      '{10'd0,     16'd1024,  16'd1,     4'd4,  10'd1023,  16'd65535, 1'b1, 1'b1, 16'd65535, 16'd8191},
      '{10'd0,     16'd1024,  16'd1,     4'd4,  10'd1023,  16'd0,     1'b1, 1'b1, 16'd0,     16'd8191},
      '{10'd0,     16'd1024,  16'd1,     4'd4,  10'd1,     16'd1023,  1'b1, 1'b1, 16'd62,    16'd8199},
      '{10'd0,     16'd1024,  16'd1,     4'd4,  10'd512,   16'd3300,  1'b0, 1'b0, 16'd0,     16'd0},
      '{10'd0,     16'd1024,  16'd1,     4'd4,  10'h2AA,   16'h5555,  1'b0, 1'b0, 16'd0,     16'd0},
      '{10'd0,     16'd1024,  16'd1,     4'd4,  10'h155,   16'hAAAA,  1'b0, 1'b0, 16'd0,     16'd0},
      '{10'd1023,  16'd1024,  16'd1,     4'd4,  10'd0,     16'd65535, 1'b1, 1'b0, 16'd0,     16'd0},
      '{10'd1023,  16'd1024,  16'd1,     4'd4,  10'd1023,  16'd65535, 1'b1, 1'b0, 16'd0,     16'd0},
      '{10'h155,   16'h8000,  16'd1,     4'd4,  10'd1023,  16'd65535, 1'b1, 1'b0, 16'd0,     16'd0},
      '{10'd0,     16'hFFFF,  16'd1,     4'd4,  10'd5,     16'd3300,  1'b1, 1'b0, 16'd0,     16'd0},
      '{10'd0,     16'd0,     16'd1,     4'd4,  10'd1023,  16'd65535, 1'b1, 1'b0, 16'd0,     16'd0},
      '{10'd0,     16'h7FFF,  16'd0,     4'd0,  10'd100,   16'd65535, 1'b1, 1'b0, 16'd65535, 16'd0},
      '{10'd0,     16'h7FFF,  16'd0,     4'd0,  10'd1,     16'd65535, 1'b1, 1'b0, 16'd65535, 16'd0},
      '{10'd0,     16'd1024,  16'd65535, 4'd15, 10'd1023,  16'd65535, 1'b1, 1'b0, 16'd0,     16'd0},
      '{10'd0,     16'd1024,  16'd65535, 4'd0,  10'd1023,  16'd65535, 1'b1, 1'b0, 16'd1000,  16'd0},
      '{10'h2AA,   16'h5555,  16'hAAAA,  4'hA,  10'd1023,  16'hFFFF,  1'b0, 1'b0, 16'd0,     16'd0},
      '{10'h155,   16'hAAAA,  16'h5555,  4'd5,  10'd0,     16'h1234,  1'b0, 1'b0, 16'd0,     16'd0},
      '{10'd0,     16'd1024,  16'd1000,  4'd0,  10'd700,   16'd3300,  1'b0, 1'b0, 16'd0,     16'd0},
      '{10'd0,     16'd1024,  16'd1000,  4'd0,  10'd300,   16'd3300,  1'b0, 1'b0, 16'd0,     16'd0}
   };

   logic clock = 1'b0;
   logic reset;

   csra_chan_if #(.payload_type(req_item_type)) req_chan ();
   csra_chan_if #(.payload_type(rsp_item_type)) rsp_chan ();
   csra_chan_if #(.payload_type(csr_item_type)) csr_chan ();

   current_sense_rolling_average u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   logic [RAW_W-1:0]         cal_offset;
   logic signed [GAIN_W-1:0] cal_gain;
   logic [DATA_W-1:0]        cal_shunt;
   logic [SHIFT_W-1:0]       cal_shift;
   logic [DATA_W-1:0]        ma_history [AVG_DEPTH_DEF];
   logic [18:0]              ma_total;
   logic [DEPTH_SHIFT-1:0]   ma_slot;
   rsp_item_type             pending_readings [$];

   int errors = 0;
   int sent_count = 0;
   int checked_count = 0;
   int settings_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [DATA_W-1:0] calc_current_ma(logic [RAW_W-1:0] raw,
                                                         logic [SUPPLY_W-1:0] supply);
      logic signed [RAW_W+1:0] diff;
      logic signed [PROD_W:0]  prod;
      longint unsigned         code;
      longint unsigned         mv;
      longint unsigned         shunt;
      longint unsigned         ma;
      diff = $signed({2'b00, raw}) - $signed({2'b00, cal_offset});
      prod = diff * cal_gain;
      if (prod <= 0) begin
         code = 0;
      end else if ((prod >>> Q_SHIFT) > CODE_MAX) begin
         code = CODE_MAX;
      end else begin
         code = prod >>> Q_SHIFT;
      end
      mv = code * supply / ADC_FULL_SCALE_DEF;
      shunt = (cal_shunt == '0) ? 1 : cal_shunt;
      ma = (mv * MV_SCALE / shunt) >> cal_shift;
      return (ma > 16'hFFFF) ? 16'hFFFF : ma[DATA_W-1:0];
   endfunction

   function automatic rsp_item_type advance_ring(req_item_type sample);
      rsp_item_type reading;
      reading.current_ma = calc_current_ma(sample.raw_sample, sample.supply_mv);
      ma_total = ma_total - 19'(ma_history[ma_slot]) + 19'(reading.current_ma);
      ma_history[ma_slot] = reading.current_ma;
      ma_slot = ma_slot + DEPTH_SHIFT'(1);
      reading.average_ma = DATA_W'(ma_total >> DEPTH_SHIFT);
      return reading;
   endfunction

   task automatic write_reg(csr_index_type idx, logic [DATA_W-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.payload <= csr_item_type'{idx, data};
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
   endtask

   task automatic apply_settings(logic [RAW_W-1:0] offset, logic [GAIN_W-1:0] gain,
                                 logic [DATA_W-1:0] shunt, logic [SHIFT_W-1:0] shift);
      req_chan.valid <= 1'b0;
      while (pending_readings.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      write_reg(CSR_OFFSET, {6'($urandom), offset});
      write_reg(CSR_GAIN, gain);
      write_reg(CSR_SHUNT, shunt);
      write_reg(CSR_SHIFT, {12'($urandom), shift});
      csr_chan.valid <= 1'b0;
      cal_offset = offset;
      cal_gain = gain;
      cal_shunt = shunt;
      cal_shift = shift;
      settings_count++;
   endtask

   task automatic send_sample(req_item_type sample, logic chk_cur, logic chk_avg,
                              logic [DATA_W-1:0] cur, logic [DATA_W-1:0] avg);
      rsp_item_type reading;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= sample;
      do @(posedge clock); while (!req_chan.ready);
      reading = advance_ring(sample);
      if (chk_cur) reading.current_ma = cur;
      if (chk_avg) reading.average_ma = avg;
      pending_readings.push_back(reading);
      sent_count++;
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : watch_readings
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.payload;
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected reading current_ma %0d average_ma %0d",
                     $time, got.current_ma, got.average_ma);
            errors++;
         end else begin
            want = pending_readings.pop_front();
            checked_count++;
            if (got.current_ma !== want.current_ma) begin
               $display("%0t: current_ma expected %0d actual %0d",
                        $time, want.current_ma, got.current_ma);
               errors++;
            end
            if (got.average_ma !== want.average_ma) begin
               $display("%0t: average_ma expected %0d actual %0d",
                        $time, want.average_ma, got.average_ma);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d readings outstanding", $time,
                  pending_readings.size());
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : stimulus
      req_item_type sample;
      dir_row_type  row;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      csr_chan.valid = 1'b0;
      csr_chan.payload = '0;
      rsp_chan.ready = 1'b0;
      cal_offset = OFFSET_RST;
      cal_gain = GAIN_RST;
      cal_shunt = SHUNT_RST;
      cal_shift = SHIFT_RST;
      for (int i = 0; i < AVG_DEPTH_DEF; i++) ma_history[i] = '0;
      ma_total = '0;
      ma_slot = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         row = DIR_TABLE[i];
         if (i == 0 || row.cfg_offset != cal_offset || row.cfg_gain != cal_gain ||
             row.cfg_shunt != cal_shunt || row.cfg_shift != cal_shift) begin
            apply_settings(row.cfg_offset, row.cfg_gain, row.cfg_shunt, row.cfg_shift);
         end
         sample.raw_sample = row.raw;
         sample.supply_mv = row.supply;
         send_sample(sample, row.chk_cur, row.chk_avg, row.cur, row.avg);
      end

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0: begin
               apply_settings(10'd0, 16'h7FFF, 16'd1, 4'd0);
            end
            1: begin
               apply_settings(10'h3FF, 16'h8000, 16'hFFFF, 4'hF);
            end
            default: begin
               apply_settings(
                  ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 64)),
                  ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(700, 2000)),
                  ($urandom_range(0, 7) == 0) ? 16'd0 :
                     ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 20)),
                  4'($urandom_range(0, 15)));
            end
         endcase
         case (seg % 4)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 56;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 56;
            end
            default: begin
               send_idle_pct = 28;
               recv_stall_pct = 28;
            end
         endcase
         repeat (SEG_ITEMS) begin
            sample.raw_sample = 10'($urandom_range(0, 1023));
            sample.supply_mv = ($urandom_range(0, 2) == 0) ? 16'($urandom) :
                                                             16'($urandom_range(1800, 5500));
            send_sample(sample, 1'b0, 1'b0, '0, '0);
         end
      end

      req_chan.valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d ADC samples sent, %0d current/average readings compared", sent_count,
               checked_count);
      $display("%0d calibration settings, four pacing modes, %0d errors", settings_count,
               errors);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
